// ===== design/deswp_pkg.sv =====
// Package for the double-ended queue with end swap.
// Holds operation and status codes, field widths and the control bundle
// shared by the top level and the storage cells. No dependencies.
package deswp_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;
    localparam int OUT_TDATA_W   = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_SWAP_ENDS  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation as seen by every cell, after the full/empty checks
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  front_data;
        logic [DATA_W-1:0]  back_data;
    } cell_ctrl_t;

endpackage

// ===== design/deswp_cell.sv =====
// One storage cell of the deque chain: holds one entry, shifts to and from
// its neighbors and offers its entry when it is the last one held.
// Depends on deswp_pkg.
module deswp_cell
    import deswp_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [CW-1:0]     count,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] tap
);

    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);
    localparam bit            IS_FIRST = (IDX == 0);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_count;
    logic              is_last;

    assign at_count = (count == POS);
    assign is_last  = (count == POS_NEXT);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_PUSH_FRONT:
            begin
                data_next = IS_FIRST ? ctrl.value : left_data;
            end
            CELL_PUSH_BACK:
            begin
                if (at_count)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_POP_FRONT:
            begin
                data_next = right_data;
            end
            CELL_SWAP:
            begin
                // first and last differ here: swap needs two or more entries
                if (IS_FIRST)
                begin
                    data_next = ctrl.back_data;
                end
                else if (is_last)
                begin
                    data_next = ctrl.front_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = is_last ? data_reg : '0;

endmodule

// ===== design/double_ended_queue_swap_ends.sv =====
// Double-ended queue with end swap, held in a chain of shifting cells.
// Result beat becomes valid in the cycle after the input beat is accepted.
// The single output register blocks intake until its beat is taken.
// Back reads go through an OR tree of taps.
// Reset clears the entry count and the output valid; cell contents are not
// reset and are never read before being written.
module double_ended_queue_swap_ends
    import deswp_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value
    input  logic [MODE_W-1:0]      s_tuser,   // [2:0] mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [31:0] popped, [33:32] status,
                                              // [38:34] occupancy, [39] zero
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);
    localparam logic [CW-1:0] TWO        = CW'(2);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [DATA_W-1:0]   popped_reg;
    logic [DATA_W-1:0]   popped_next;
    status_t             status_reg;
    status_t             status_next;

    cell_ctrl_t          ctrl;
    logic                accept;
    mode_t               mode;
    logic                full;
    logic                empty;
    logic [DATA_W-1:0]   cell_data [DEPTH];
    logic [DATA_W-1:0]   cell_tap  [DEPTH];
    logic [DATA_W-1:0]   back_data;

    assign s_tready = !m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser);
    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);

    // only the last held cell drives a nonzero tap
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | cell_tap[i];
        end
    end

    always_comb
    begin
        ctrl.op         = CELL_HOLD;
        ctrl.value      = s_tdata;
        ctrl.front_data = cell_data[0];
        ctrl.back_data  = back_data;
        count_next      = count_reg;
        popped_next     = popped_reg;
        status_next     = status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        if (accept)
        begin
            m_tvalid_next = 1'b1;
            popped_next   = '0;
            status_next   = ST_OK;
            unique case (mode)
                MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.op    = CELL_PUSH_FRONT;
                        count_next = count_reg + ONE;
                    end
                end
                MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.op    = CELL_PUSH_BACK;
                        count_next = count_reg + ONE;
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op     = CELL_POP_FRONT;
                        popped_next = cell_data[0];
                        count_next  = count_reg - ONE;
                    end
                end
                MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        popped_next = back_data;
                        count_next  = count_reg - ONE;
                    end
                end
                MODE_SWAP_ENDS:
                begin
                    if (count_reg >= TWO)
                    begin
                        ctrl.op = CELL_SWAP;
                    end
                end
                default:
                begin
                    ctrl.op = CELL_HOLD;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = s_tdata;
        end
        else
        begin : g_mid
            assign left_in = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_end
            assign right_in = cell_data[g];
        end
        else
        begin : g_inner
            assign right_in = cell_data[g+1];
        end

        deswp_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[g]),
            .tap        (cell_tap[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, OCC_W'(count_reg), status_reg, popped_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid_reg)
        else $error("accepted beat produced no result");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> count_reg == $past(count_reg))
        else $error("entry count moved without an accepted beat");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> m_tdata[38:34] == OCC_W'(count_reg))
        else $error("reported occupancy differs from entry count");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && status_reg != ST_OK) |-> popped_reg == '0)
        else $error("failed operation returned data");

endmodule

// ===== bench/deq_swap_checker.sv =====
// Checker for the double-ended queue with end swap: watches both stream
// channels, predicts every result beat from its own copy of the queue and
// compares field by field. Depends on deswp_pkg.
module deq_swap_checker
    import deswp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value
    input  logic [MODE_W-1:0]      s_tuser,   // [2:0] mode
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] popped, [33:32] status,
                                              // [38:34] occupancy, [39] zero
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        logic [DATA_W-1:0] popped;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
    } deq_result_t;

    logic [DATA_W-1:0] slots [QDEPTH];
    int unsigned       head_slot;
    int unsigned       fill_level;
    deq_result_t       pending_results [$];

    function automatic int unsigned ring_slot(input int unsigned offset);
        return (head_slot + offset) % QDEPTH;
    endfunction

    task automatic predict_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
        deq_result_t       res;
        int unsigned       tail;
        logic [DATA_W-1:0] held;
        res.popped = '0;
        res.status = ST_OK;
        case (mode)
            MODE_PUSH_FRONT:
                if (fill_level >= QDEPTH)
                    res.status = ST_FULL;
                else
                begin
                    head_slot = ring_slot(QDEPTH - 1);
                    slots[head_slot] = value;
                    fill_level++;
                end
            MODE_PUSH_BACK:
                if (fill_level >= QDEPTH)
                    res.status = ST_FULL;
                else
                begin
                    slots[ring_slot(fill_level)] = value;
                    fill_level++;
                end
            MODE_POP_FRONT:
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.popped = slots[head_slot];
                    head_slot = ring_slot(1);
                    fill_level--;
                end
            MODE_POP_BACK:
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.popped = slots[ring_slot(fill_level - 1)];
                    fill_level--;
                end
            MODE_SWAP_ENDS:
                if (fill_level >= 2)
                begin
                    tail = ring_slot(fill_level - 1);
                    held = slots[head_slot];
                    slots[head_slot] = slots[tail];
                    slots[tail] = held;
                end
            default:
                ;  // reserved modes leave everything alone
        endcase
        res.occupancy = fill_level[OCC_W-1:0];
        pending_results.push_back(res);
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] beat);
        deq_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result beat with nothing expected: tdata=%h", beat);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (beat[31:0] !== want.popped)
        begin
            $error("popped: expected %0d, actual %0d", $signed(want.popped),
                   $signed(beat[31:0]));
            mismatches++;
        end
        if (beat[33:32] !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, beat[33:32]);
            mismatches++;
        end
        if (beat[38:34] !== want.occupancy)
        begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, beat[38:34]);
            mismatches++;
        end
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot = 0;
            fill_level = 0;
            pending_results.delete();
        end
        else
        begin
            // check the outgoing beat first: a beat taken at this edge can
            // never belong to an item accepted at the same edge
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                predict_op(s_tuser, s_tdata);
        end
        outstanding = pending_results.size();
    end

endmodule

// ===== bench/tb.sv =====
// Top of the bench for the double-ended queue with end swap: clock, reset,
// stimulus, output back-pressure and verdict. Depends on deswp_pkg, the
// block itself and deq_swap_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deswp_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int GAP_MAX      = 18;
    localparam int IDLE_LIMIT   = 2000;
    localparam int QDEPTH_FILL  = DEPTH_DEFAULT - 2;

    localparam logic [MODE_W-1:0] MODE_RESERVED_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESERVED_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RESERVED_C = 3'd7;

    localparam logic [DATA_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;   // [31:0] value
    logic [MODE_W-1:0]      s_tuser;   // [2:0] mode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] popped, [33:32] status,
                                       // [38:34] occupancy, [39] zero
    int                     mismatches;
    int                     outstanding;
    int                     idle_cycles = 0;
    bit                     sender_steady = 1'b0;
    bit                     receiver_steady = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    double_ended_queue_swap_ends u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    deq_swap_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(GAP_MAX, 0);
        if (gap > 0)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // hold off intake until every predicted beat has been taken
    task automatic wait_drained();
        @(negedge clk) s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9, 0))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // filling leans on pushes, draining on pops, so both ends get hit
    function automatic logic [MODE_W-1:0] pick_mode(input bit filling);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 4)
        begin
            case (roll % 3)
                0: return MODE_RESERVED_A;
                1: return MODE_RESERVED_B;
                default: return MODE_RESERVED_C;
            endcase
        end
        if (roll < 14)
            return MODE_SWAP_ENDS;
        if (roll < (filling ? 84 : 28))
            return $urandom_range(1, 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        return $urandom_range(1, 0) ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    task automatic run_directed();
        int k;
        // empty queue: both pops fail, swap and reserved modes do nothing
        send_op(MODE_POP_FRONT, VALUE_MAX);
        send_op(MODE_POP_BACK, VALUE_MIN);
        send_op(MODE_SWAP_ENDS, '1);
        send_op(MODE_RESERVED_A, '1);
        // single entry swap, then two entry swap
        send_op(MODE_PUSH_BACK, VALUE_MIN);
        send_op(MODE_SWAP_ENDS, '0);
        send_op(MODE_PUSH_FRONT, VALUE_MAX);
        send_op(MODE_SWAP_ENDS, '0);
        send_op(MODE_RESERVED_B, '0);
        send_op(MODE_RESERVED_C, VALUE_MIN);
        // fill to the top from both ends
        for (k = 0; k < QDEPTH_FILL; k++)
            send_op(k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, k[1] ? '1 : '0);
        send_op(MODE_PUSH_FRONT, VALUE_MAX);
        send_op(MODE_PUSH_BACK, VALUE_MIN);
        send_op(MODE_SWAP_ENDS, '1);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_POP_BACK, '1);
    endtask

    initial
    begin
        int i;
        int trend_left;
        bit filling;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        filling  = 1'b1;
        trend_left = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                sender_steady = ($urandom_range(3, 0) == 0);
            if (trend_left == 0)
            begin
                filling = !filling;
                trend_left = $urandom_range(60, 20);
            end
            trend_left--;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            send_op(pick_mode(filling), pick_value());
        end
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("double_ended_queue_swap_ends verification clean");
        else
            $display("double_ended_queue_swap_ends verification failed");
        $finish;
    end

    initial
    begin
        int stall;
        int beats;
        beats = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 40 == 0)
                receiver_steady = ($urandom_range(3, 0) == 0);
            stall = receiver_steady ? 0 : $urandom_range(GAP_MAX, 0);
            if (stall > 0)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            beats++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("double_ended_queue_swap_ends verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
